/* rtl/core/rhi_pkg.sv */
`default_nettype none

package rhi_pkg;

  // default saturation point of h and of the clamped counts
  localparam int MAX_ITEMS_DEF = 65536;

  localparam int CIT_W       = 32;
  localparam int H_W         = 17;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  // set tag kept beside each histogram entry
  localparam int EPOCH_W = 8;

  localparam int OUT_DEPTH = 2;

  typedef struct packed {
    logic           set_done;
    logic [H_W-1:0] h_index;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/rhi_ram.sv */
`default_nettype none

module rhi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/running_h_index.sv */
`default_nettype none

// channel   dir  tdata                       tlast
// s_axis    in   [31:0] citations            last_in_set
// m_axis    out  [16:0] h_index, rest zero   set_done
//
// an item holds off the next one while busy: the histogram ram has one read
// port and an item may read twice (its own count entry, then the entry just
// above the new h). reset runs a clearing pass over all MAX_ITEMS+1 entries of
// the histogram ram; the same pass runs after every 2**EPOCH_W sets, otherwise
// a new set only bumps the set tag. the result of an item is queued in a 2-word
// output buffer, so a stalled m_axis holds input only once both words are full

module running_h_index #(
  parameter int MAX_ITEMS = rhi_pkg::MAX_ITEMS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [rhi_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // citations
  input  wire logic                             s_axis_tlast,   // last_in_set
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic      [rhi_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // h_index, zero pad
  output logic                                  m_axis_tlast    // set_done
);

  import rhi_pkg::*;

  localparam int CW    = $clog2(MAX_ITEMS + 1);
  localparam int DEPTH = MAX_ITEMS + 1;
  localparam int MW    = EPOCH_W + CW;
  localparam int OPW   = $clog2(OUT_DEPTH);
  localparam int OCW   = $clog2(OUT_DEPTH + 1);

  localparam logic [CW-1:0] H_MAX = CW'(MAX_ITEMS);

  // running state
  logic [CW-1:0]      cur_h;
  logic [CW-1:0]      above;
  logic [CW-1:0]      nxt;        // histogram count at cur_h + 1
  logic [EPOCH_W-1:0] epoch;
  logic               busy;
  logic               sweep;
  logic [CW-1:0]      sweep_addr;

  // deferred work of the item in flight
  logic               rmw_q;
  logic [CW-1:0]      rmw_addr;
  logic               rl_q;
  logic [CW-1:0]      rl_addr;
  logic               rld_q;
  logic               fwd_q;
  logic [CW-1:0]      fwd_cnt;

  // ram port
  logic               ram_we;
  logic [CW-1:0]      ram_waddr;
  logic [MW-1:0]      ram_wdata;
  logic               ram_re;
  logic [CW-1:0]      ram_raddr;
  logic [MW-1:0]      ram_rdata;
  logic [CW-1:0]      rd_cnt;

  // item step
  logic               accept;
  logic               last;
  logic [CW-1:0]      v;
  logic [CW-1:0]      nxt_eff;
  logic [CW-1:0]      h_p1;
  logic               gt;
  logic               eq1;
  logic [CW-1:0]      above1;
  logic               inc;
  logic [CW-1:0]      nxt_inc;
  logic [CW-1:0]      h_step;
  logic [CW-1:0]      above_step;
  logic [CW-1:0]      nxt_step;
  logic               rmw_need;
  logic               rl_need;

  // output buffer
  result_t            out_buf [OUT_DEPTH];
  logic [OPW-1:0]     wr_ptr;
  logic [OPW-1:0]     rd_ptr;
  logic [OCW-1:0]     out_cnt;
  logic               pop;
  result_t            head;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign last   = s_axis_tlast;
  assign pop    = m_axis_tvalid && m_axis_tready;

  assign s_axis_tready = !busy && !sweep && (out_cnt != OCW'(OUT_DEPTH));

  // entries tagged with an older set read as zero
  assign rd_cnt = (ram_rdata[MW-1 -: EPOCH_W] == epoch) ? ram_rdata[CW-1:0] : '0;

  always_comb begin
    v = (s_axis_tdata > CIT_W'(MAX_ITEMS)) ? H_MAX : s_axis_tdata[CW-1:0];
    // the reload of nxt lands in the cycle a following item may be taken
    nxt_eff    = rld_q ? (fwd_q ? fwd_cnt : rd_cnt) : nxt;
    h_p1       = cur_h + CW'(1);
    gt         = v > cur_h;
    eq1        = gt && (v == h_p1);
    above1     = above + CW'(gt);
    inc        = (above1 > cur_h) && (cur_h != H_MAX);
    nxt_inc    = nxt_eff + CW'(eq1);
    h_step     = inc ? h_p1 : cur_h;
    above_step = above1;
    if (inc) begin
      above_step = (nxt_inc <= above1) ? above1 - nxt_inc : '0;
    end
    nxt_step   = inc ? '0 : nxt_inc;
    // entries at or below h are never read again, so the one at h+1 lives in nxt
    rmw_need   = gt && !eq1 && !last;
    rl_need    = inc && (h_p1 != H_MAX) && !last;
  end

  always_comb begin
    ram_re    = (accept && rmw_need) || rl_q;
    ram_raddr = rl_q ? rl_addr : v;
    ram_we    = sweep || rmw_q;
    ram_waddr = sweep ? sweep_addr : rmw_addr;
    ram_wdata = sweep ? '0 : {epoch, rd_cnt + CW'(1)};
  end

  rhi_ram #(
    .WIDTH (MW),
    .DEPTH (DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_h      <= '0;
      above      <= '0;
      nxt        <= '0;
      epoch      <= '0;
      busy       <= 1'b0;
      sweep      <= 1'b1;
      sweep_addr <= '0;
      rmw_q      <= 1'b0;
      rl_q       <= 1'b0;
      rld_q      <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      busy  <= accept;
      rmw_q <= accept && rmw_need;
      rl_q  <= accept && rl_need;
      rld_q <= rl_q;
      fwd_q <= rmw_q && rl_q && (rmw_addr == rl_addr);

      if (accept) begin
        if (last) begin
          cur_h <= '0;
          above <= '0;
          nxt   <= '0;
          epoch <= epoch + EPOCH_W'(1);
        end else begin
          cur_h <= h_step;
          above <= above_step;
          nxt   <= nxt_step;
        end
      end else if (rld_q) begin
        nxt <= nxt_eff;
      end

      if (sweep) begin
        sweep_addr <= sweep_addr + CW'(1);
        if (sweep_addr == H_MAX) begin
          sweep <= 1'b0;
        end
      end else if (accept && last && (epoch == '1)) begin
        // tag wraps to zero: stale entries could match again
        sweep      <= 1'b1;
        sweep_addr <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rmw_addr <= v;
      rl_addr  <= h_p1 + CW'(1);
    end
    fwd_cnt <= rd_cnt + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      out_cnt <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + OPW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OPW'(1);
      end
      out_cnt <= out_cnt + OCW'(accept) - OCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_buf[wr_ptr] <= '{set_done: last, h_index: H_W'(h_step)};
    end
  end

  assign head          = out_buf[rd_ptr];
  assign m_axis_tvalid = (out_cnt != '0);
  assign m_axis_tdata  = OUT_TDATA_W'(head.h_index);
  assign m_axis_tlast  = head.set_done;

  a_one_word_per_two: assert property (@(posedge clk) disable iff (rst)
    accept |=> !accept)
    else $error("words taken in adjacent cycles");

  a_above_le_h: assert property (@(posedge clk) disable iff (rst)
    above <= cur_h)
    else $error("above count exceeds h");

  a_h_saturates: assert property (@(posedge clk) disable iff (rst)
    cur_h <= H_MAX)
    else $error("h beyond saturation");

  a_read_port_free: assert property (@(posedge clk) disable iff (rst)
    !(rl_q && accept && rmw_need))
    else $error("two reads on the histogram port");

  a_write_port_free: assert property (@(posedge clk) disable iff (rst)
    !(sweep && rmw_q))
    else $error("clearing pass collides with an update");

  a_buffer_bound: assert property (@(posedge clk) disable iff (rst)
    out_cnt <= OCW'(OUT_DEPTH))
    else $error("output buffer overrun");

endmodule

`default_nettype wire

/* verif/testbench.sv */
`default_nettype none

module testbench;
  import rhi_pkg::*;

  localparam int unsigned CLAMP       = MAX_ITEMS_DEF;
  localparam int          QUIET_LIMIT = 400000;
  localparam int          DRAIN       = 20;

  typedef struct packed {
    logic [CIT_W-1:0] cit;
    logic             last;
  } cite_item_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  running_h_index i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  cite_item_t  pending_cites[$];
  result_t     expected_h[$];
  int          n_total = 0;
  int          n_sent = 0;
  int          n_taken = 0;
  int          n_out = 0;
  int          n_fail = 0;
  int          quiet = 0;
  bit          in_fired = 1'b0;

  // running h-index state of the current set
  int unsigned h_now = 0;
  int unsigned above_h = 0;
  int unsigned count_hist[int unsigned];

  function automatic result_t next_h_index(input logic [CIT_W-1:0] cit, input logic last);
    int unsigned v;
    int unsigned drop;
    result_t     r;
    v = (cit > CLAMP) ? CLAMP : cit;
    if (v > h_now) begin
      above_h++;
      if (count_hist.exists(v)) count_hist[v] = count_hist[v] + 1;
      else count_hist[v] = 1;
    end
    if (above_h > h_now && h_now < CLAMP) begin
      h_now++;
      drop = count_hist.exists(h_now) ? count_hist[h_now] : 0;
      above_h = (drop <= above_h) ? above_h - drop : 0;
      count_hist[h_now] = 0;
    end
    r.h_index  = h_now[H_W-1:0];
    r.set_done = last;
    if (last) begin
      count_hist.delete();
      h_now   = 0;
      above_h = 0;
    end
    return r;
  endfunction

  task automatic push_cite(input logic [CIT_W-1:0] cit, input logic last);
    cite_item_t it;
    it.cit  = cit;
    it.last = last;
    pending_cites.push_back(it);
    n_total++;
  endtask

  // word source
  always @(negedge clk) begin : drive
    cite_item_t nxt;
    bit         calm;
    calm = (n_sent >= 500 && n_sent < 800);
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fired) begin
      if (pending_cites.size() > 0 && (calm || $urandom_range(0, 99) >= 11)) begin
        nxt = pending_cites.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.cit;
        s_axis_tlast  <= nxt.last;
        n_sent++;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // word sink backpressure
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (n_out >= 300 && n_out < 600) || ($urandom_range(0, 99) >= 11);
    end
  end

  always @(posedge clk) begin : observe
    result_t want;
    in_fired = 1'b0;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_fired = 1'b1;
        n_taken++;
        expected_h.push_back(next_h_index(s_axis_tdata, s_axis_tlast));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        n_out++;
        if (expected_h.size() == 0) begin
          $error("unexpected word: h_index %0d set_done %0d",
                 m_axis_tdata[H_W-1:0], m_axis_tlast);
          n_fail++;
        end else begin
          want = expected_h.pop_front();
          if (m_axis_tdata[H_W-1:0] !== want.h_index) begin
            $error("h_index: expected %0d, got %0d", want.h_index, m_axis_tdata[H_W-1:0]);
            n_fail++;
          end
          if (m_axis_tlast !== want.set_done) begin
            $error("set_done: expected %0d, got %0d", want.set_done, m_axis_tlast);
            n_fail++;
          end
          if (m_axis_tdata[OUT_TDATA_W-1:H_W] !== '0) begin
            $error("pad: expected 0, got %0h", m_axis_tdata[OUT_TDATA_W-1:H_W]);
            n_fail++;
          end
        end
      end
      // reset and every 256th set trigger a long ram clearing pass
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QUIET_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int len;
    int sets;
    int k;
    int pick;
    logic [CIT_W-1:0] c;

    // single-item sets, huge and zero counts
    push_cite(32'd0, 1'b1);
    push_cite(32'hFFFF_FFFF, 1'b1);
    // clamp boundary
    push_cite(32'd65535, 1'b0);
    push_cite(32'd65536, 1'b0);
    push_cite(32'd65537, 1'b1);
    push_cite(32'hAAAA_AAAA, 1'b0);
    push_cite(32'h5555_5555, 1'b1);
    // equal counts stall h
    push_cite(32'd1, 1'b0);
    push_cite(32'd1, 1'b0);
    push_cite(32'd1, 1'b1);
    push_cite(32'd3, 1'b0);
    push_cite(32'd3, 1'b0);
    push_cite(32'd3, 1'b0);
    push_cite(32'd3, 1'b1);
    push_cite(32'd0, 1'b0);
    push_cite(32'd5, 1'b0);
    push_cite(32'd2, 1'b0);
    push_cite(32'd2, 1'b0);
    push_cite(32'd9, 1'b0);
    push_cite(32'd1, 1'b0);
    push_cite(32'd4, 1'b1);

    // short sets mostly, so the set tag wraps around
    sets = 0;
    while (n_total < 1350) begin
      pick = $urandom_range(0, 99);
      if (pick < 92) len = $urandom_range(1, 4);
      else if (pick < 98) len = $urandom_range(5, 25);
      else len = $urandom_range(40, 100);
      for (k = 0; k < len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) c = $urandom_range(0, len + 1);
        else if (pick < 75) c = $urandom_range(0, 2 * len + 3);
        else if (pick < 85) c = $urandom;
        else if (pick < 93) begin
          case ($urandom_range(0, 4))
            0: c = 32'd65535;
            1: c = 32'd65536;
            2: c = 32'd65537;
            3: c = 32'hFFFF_FFFF;
            default: c = 32'd0;
          endcase
        end else c = $urandom_range(0, 70000);
        push_cite(c, k == len - 1);
      end
      sets++;
    end

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    while (n_taken < n_total || expected_h.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (expected_h.size() != 0) begin
      $error("%0d results never arrived", expected_h.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/core/rhi_pkg.sv
rtl/core/rhi_ram.sv
rtl/core/running_h_index.sv
verif/testbench.sv
